FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/hcdh_pkg.sv
// Types, codes and constants of the hit code decoder histogram.
`default_nettype none

package hcdh_pkg;

  localparam int MaxColumnsDef   = 8;
  localparam int MaxTotalRowsDef = 64;
  localparam int CountWidthDef   = 32;
  localparam int Channels        = 16;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 64;

  // request types
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EARLY_END = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // byte codes (upper nibble)
  localparam logic [3:0] CODE_END     = 4'd0;
  localparam logic [3:0] CODE_HIT     = 4'd4;
  localparam logic [3:0] CODE_COL     = 4'd5;
  localparam logic [3:0] CODE_HIT_ROW = 4'd6;
  localparam logic [3:0] CODE_ROW     = 4'd7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_COLUMN_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS_PACKED  = 1'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       last_in_event;
    logic [9:0] read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count_value;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic rd;
    logic wr_hit;
    logic clr_step;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       hit_ok;
    logic       clr_last;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/hcdh_ctrl.sv
// Sequencing state machine of the hit code decoder histogram.
`default_nettype none

module hcdh_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic start_i,
  input  wire hcdh_pkg::dp_sts_t   sts_i,
  output hcdh_pkg::dp_cmd_t        cmd_o,
  output logic                     busy_o
);
  import hcdh_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       clr_emit_q, clr_emit_d;

  always_comb begin
    state_d    = state_q;
    clr_emit_d = clr_emit_q;
    cmd_o      = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.emit = clr_emit_q;
          clr_emit_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        priority if (sts_i.req_type == REQ_CLEAR) begin
          clr_emit_d = 1'b1;
          state_d    = S_CLEAR;
        end else if (sts_i.req_type == REQ_READ || sts_i.hit_ok) begin
          state_d = S_READ;
        end else begin
          state_d = S_FIN;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        cmd_o.wr_hit = 1'b1;
        cmd_o.emit   = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // reset lands in the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_emit_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_emit_q <= clr_emit_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/hcdh_datapath.sv
// Decoder, position registers, configuration and counter store.
`default_nettype none

module hcdh_datapath #(
  parameter int MAX_COLUMNS    = hcdh_pkg::MaxColumnsDef,
  parameter int MAX_TOTAL_ROWS = hcdh_pkg::MaxTotalRowsDef,
  parameter int COUNT_WIDTH    = hcdh_pkg::CountWidthDef
) (
  input  wire                 logic                         clk_i,
  input  wire                 logic                         rst_ni,
  input  wire hcdh_pkg::item_t                              item_i,
  input  wire hcdh_pkg::dp_cmd_t                            cmd_i,
  output hcdh_pkg::dp_sts_t                                 sts_o,
  input  wire                 logic                         cfg_we_i,
  input  wire                 logic [hcdh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire                 logic [hcdh_pkg::CfgDataW-1:0] cfg_data_i,
  output hcdh_pkg::result_t                                 result_o,
  output logic                                              done_o
);
  import hcdh_pkg::*;

  localparam int StoreSize = MAX_TOTAL_ROWS * Channels;
  localparam int AW        = $clog2(StoreSize);

  // configuration
  logic [3:0]  col_count_q;
  logic [63:0] rows_packed_q;

  // position and latched item
  logic [3:0] col_pos_q, col_pos_d;
  logic [7:0] row_pos_q, row_pos_d;
  item_t      item_q;

  // decoded item
  logic [AW-1:0] addr_q;
  logic [1:0]    status_q;
  logic          hit_q, read_q, rin_q;

  logic [COUNT_WIDTH-1:0] mem [StoreSize];
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic [AW-1:0]          clr_addr_q;
  logic [63:0]            rd_wide;
  logic [31:0]            rd_low;

  logic [3:0]  code, chan, used_cols;
  logic [10:0] base, grow;
  logic [7:0]  col_rows;
  logic        in_range, hit_code, hit_ok, rd_in_range;
  logic [1:0]  status_d;
  logic [AW-1:0] hit_addr, rd_addr;

  assign code = item_q.data_byte[7:4];
  assign chan = item_q.data_byte[3:0];

  assign used_cols = (col_count_q > 4'(MAX_COLUMNS)) ? 4'(MAX_COLUMNS) : col_count_q;
  assign col_rows  = rows_packed_q[{col_pos_q[2:0], 3'b000} +: 8];

  // first global row of the current column
  always_comb begin
    base = '0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (4'(c) < col_pos_q) base = base + {3'b000, rows_packed_q[c*8 +: 8]};
    end
  end

  assign grow     = base + {3'b000, row_pos_q};
  assign in_range = (col_pos_q < used_cols) && (row_pos_q < col_rows) &&
                    (grow < 11'(MAX_TOTAL_ROWS));
  assign hit_code = (code == CODE_HIT) || (code == CODE_HIT_ROW);
  assign hit_ok   = (item_q.req_type == REQ_DATA) && hit_code && in_range;
  assign hit_addr = AW'({grow, chan});
  assign rd_addr  = AW'(item_q.read_index);
  assign rd_in_range = 13'(item_q.read_index) < 13'(StoreSize);

  // position update and status of a data byte
  always_comb begin
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    status_d  = ST_OK;
    if (item_q.req_type == REQ_DATA) begin
      unique case (code)
        CODE_END: begin
          if (!item_q.last_in_event) status_d = ST_EARLY_END;
          col_pos_d = '0;
          row_pos_d = '0;
        end
        CODE_HIT: begin
          if (!in_range) status_d = ST_RANGE;
        end
        CODE_COL: begin
          row_pos_d = '0;
          if (col_pos_q != 4'hf) col_pos_d = col_pos_q + 4'd1;
        end
        CODE_HIT_ROW: begin
          if (!in_range) status_d = ST_RANGE;
          if (row_pos_q != 8'hff) row_pos_d = row_pos_q + 8'd1;
        end
        CODE_ROW: begin
          if (row_pos_q != 8'hff) row_pos_d = row_pos_q + 8'd1;
        end
        default: status_d = ST_UNKNOWN;
      endcase
      if (item_q.last_in_event) begin
        col_pos_d = '0;
        row_pos_d = '0;
      end
    end
  end

  assign sts_o.req_type = item_q.req_type;
  assign sts_o.hit_ok   = hit_ok;
  assign sts_o.clr_last = (clr_addr_q == AW'(StoreSize - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q   <= '0;
      rows_packed_q <= '0;
      col_pos_q     <= '0;
      row_pos_q     <= '0;
      hit_q         <= 1'b0;
      read_q        <= 1'b0;
      clr_addr_q    <= '0;
      done_o        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_COLUMN_COUNT: col_count_q   <= cfg_data_i[3:0];
          CFG_ROWS_PACKED:  rows_packed_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.calc) begin
        col_pos_q <= col_pos_d;
        row_pos_q <= row_pos_d;
        hit_q     <= hit_ok;
        read_q    <= (item_q.req_type == REQ_READ);
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + AW'(1);
      end
      done_o <= cmd_i.emit;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.calc) begin
      status_q <= status_d;
      rin_q    <= rd_in_range;
      addr_q   <= hit_ok ? hit_addr : rd_addr;
    end
    if (cmd_i.emit) begin
      result_o.status      <= status_q;
      result_o.count_value <= (read_q && rin_q) ? rd_low : 32'd0;
    end
  end

  assign rd_wide = 64'(rdata_q);
  assign rd_low  = rd_wide[31:0];

  // counter store: one write port, one registered read port
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = (&rdata_q) ? rdata_q : rdata_q + COUNT_WIDTH'(1);
    priority if (cmd_i.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (cmd_i.wr_hit && hit_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.rd) rdata_q <= mem[addr_q];
  end

endmodule

`default_nettype wire

FILE: rtl/hit_code_decoder_histogram_unit.sv
// Top level of the hit code decoder histogram.
`default_nettype none

// Decodes detector readout bytes into per-channel hit counters.
// Input: an item is taken when start is high and busy is low. Data bytes
// (req_type 0) steer column and row and count hits; req_type 1 clears all
// counters; req_type 2 reads one counter into count_value.
// Output: each item gives one result, shown on result_o for a single cycle
// with done_o high; the receiver cannot hold it off.
// Sequence: a data byte without a counted hit passes the CALC and FIN states;
// a counted hit or a counter read passes CALC, READ and FIN (read of the
// store, then, for a hit, the saturating write back). busy drops as done_o
// rises, so a new item is taken only once the last one's result is given.
// The store's single read port and the read-modify-write it needs set this order.
// A clear request sweeps the store one counter per cycle, all MAX_TOTAL_ROWS*16
// counters (1024 at default), and its result follows the last write.
// Reset: position and configuration go to zero and the same sweep runs with
// busy high and no result given.
// Configuration: cfg_ready_o is always high; write only while busy is low.

module hit_code_decoder_histogram_unit #(
  parameter int MAX_COLUMNS    = hcdh_pkg::MaxColumnsDef,
  parameter int MAX_TOTAL_ROWS = hcdh_pkg::MaxTotalRowsDef,
  parameter int COUNT_WIDTH    = hcdh_pkg::CountWidthDef
) (
  input  wire               logic                          clk_i,
  input  wire               logic                          rst_ni,
  input  wire               logic                          start,
  output logic                                             busy,
  input  wire hcdh_pkg::item_t                             item_i,
  output logic                                             done_o,
  output hcdh_pkg::result_t                                result_o,
  input  wire               logic                          cfg_valid_i,
  output logic                                             cfg_ready_o,
  input  wire               logic [hcdh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire               logic [hcdh_pkg::CfgDataW-1:0] cfg_data_i
);
  import hcdh_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hcdh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  hcdh_datapath #(
    .MAX_COLUMNS    (MAX_COLUMNS),
    .MAX_TOTAL_ROWS (MAX_TOTAL_ROWS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o),
    .done_o      (done_o)
  );

endmodule

`default_nettype wire

FILE: rtl/hcdh_checker.sv
// Port-level checks of the hit code decoder histogram, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module hcdh_checker (
  input wire               logic clk_i,
  input wire               logic rst_ni,
  input wire               logic start,
  input wire               logic busy,
  input wire               logic done_i,
  input wire hcdh_pkg::result_t  result_i,
  input wire               logic cfg_ready_i
);
  import hcdh_pkg::*;

  // an accepted item makes the block busy
  `ASSERT_NXT(acc_sets_busy, clk_i, rst_ni, start && !busy, busy)
  // results never come back to back
  `ASSERT_NXT(no_b2b_done, clk_i, rst_ni, done_i, !done_i)
  // a result appears once the block has gone idle
  `ASSERT_IMP(done_idle, clk_i, rst_ni, done_i, !busy)
  // a result with a status other than ok carries a zero counter value
  `ASSERT_IMP(err_no_value, clk_i, rst_ni, done_i && result_i.status != ST_OK,
              result_i.count_value == 32'd0)
  `ASSERT_IMP(cfg_always_rdy, clk_i, rst_ni, !busy, cfg_ready_i)

endmodule

bind hit_code_decoder_histogram_unit hcdh_checker u_hcdh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_i      (done_o),
  .result_i    (result_o),
  .cfg_ready_i (cfg_ready_o)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the hit code decoder histogram unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcdh_pkg::*;

  localparam int MaxCols    = MaxColumnsDef;
  localparam int MaxRows    = MaxTotalRowsDef;
  localparam int StoreSize  = MaxRows * Channels;
  localparam int CycleLimit = 200000;
  localparam int DrainPad   = 8;
  localparam int MaxReports = 10;
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam logic [CountWidthDef-1:0] CountMax = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  item_t item_i;
  logic done_o;
  result_t result_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  hit_code_decoder_histogram_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]               cfg_cols;
  logic [63:0]              cfg_rows;
  logic [3:0]               col_pos;
  logic [7:0]               row_pos;
  logic [CountWidthDef-1:0] hist_model [StoreSize];

  result_t pending_results[$];

  int mismatches = 0;
  int n_items    = 0;
  int n_reads    = 0;
  int n_clears   = 0;
  int n_hits     = 0;
  int n_settings = 0;
  int burst_left = 0;
  int cycle_cnt  = 0;

  function automatic logic [7:0] rows_of(int col);
    return cfg_rows[(col % 8) * 8 +: 8];
  endfunction

  function automatic bit count_hit(logic [3:0] chan);
    int cols;
    int base;
    int grow;
    int idx;
    cols = (cfg_cols > MaxCols) ? MaxCols : int'(cfg_cols);
    if (col_pos >= cols) return 1'b0;
    base = 0;
    for (int c = 0; c < col_pos; c++) base += rows_of(c);
    if (row_pos >= rows_of(col_pos)) return 1'b0;
    grow = base + row_pos;
    if (grow >= MaxRows) return 1'b0;
    idx = grow * Channels + chan;
    if (idx >= StoreSize) return 1'b0;
    if (hist_model[idx] != CountMax) hist_model[idx]++;
    n_hits++;
    return 1'b1;
  endfunction

  function automatic void step_row();
    if (row_pos != 8'hff) row_pos++;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    logic [3:0] code;
    logic [3:0] chan;
    r.status      = ST_OK;
    r.count_value = '0;
    code = it.data_byte[7:4];
    chan = it.data_byte[3:0];
    case (it.req_type)
      REQ_DATA: begin
        case (code)
          CODE_END: begin
            if (!it.last_in_event) r.status = ST_EARLY_END;
            col_pos = '0;
            row_pos = '0;
          end
          CODE_HIT: begin
            if (!count_hit(chan)) r.status = ST_RANGE;
          end
          CODE_COL: begin
            row_pos = '0;
            if (col_pos != 4'hf) col_pos++;
          end
          CODE_HIT_ROW: begin
            if (!count_hit(chan)) r.status = ST_RANGE;
            step_row();
          end
          CODE_ROW: step_row();
          default: r.status = ST_UNKNOWN;
        endcase
        if (it.last_in_event) begin
          col_pos = '0;
          row_pos = '0;
        end
      end
      REQ_CLEAR: begin
        foreach (hist_model[k]) hist_model[k] = '0;
      end
      REQ_READ: begin
        if (it.read_index < StoreSize) r.count_value = 32'(hist_model[it.read_index]);
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: status %0d count %0d", result_o.status,
                   result_o.count_value);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status || result_o.count_value !== want.count_value) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch at cycle %0d: status exp %0d got %0d, count exp %0d got %0d",
                     cycle_cnt, want.status, result_o.status, want.count_value,
                     result_o.count_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [3:0] rand_chan();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic item_t data_item(logic [3:0] code, logic [3:0] chan, logic last);
    item_t it;
    it.req_type      = REQ_DATA;
    it.data_byte     = {code, chan};
    it.last_in_event = last;
    it.read_index    = 10'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic item_t ctrl_item(logic [1:0] req, logic [9:0] idx);
    item_t it;
    it.req_type      = req;
    it.data_byte     = 8'($urandom_range(0, 255));
    it.last_in_event = 1'($urandom_range(0, 1));
    it.read_index    = idx;
    return it;
  endfunction

  // one item through the start/busy handshake, then the sender's burst pacing
  task automatic send_item(input item_t it);
    int gap;
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_result(it));
    n_items++;
    if (it.req_type == REQ_READ) n_reads++;
    if (it.req_type == REQ_CLEAR) n_clears++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // sender holds off until every pending result is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_COLUMN_COUNT) cfg_cols = data[3:0];
    else if (idx == CFG_ROWS_PACKED) cfg_rows = data;
  endtask

  task automatic set_config(input logic [63:0] cols_word, input logic [63:0] rows_word);
    drain();
    write_reg(CFG_COLUMN_COUNT, cols_word);
    write_reg(CFG_ROWS_PACKED, rows_word);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [63:0] rows_word(int lo, int hi);
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[k*8 +: 8] = 8'($urandom_range(lo, hi));
    return w;
  endfunction

  task automatic do_reset();
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    cfg_cols = '0;
    cfg_rows = '0;
    col_pos  = '0;
    row_pos  = '0;
    foreach (hist_model[k]) hist_model[k] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // store clearing sweep runs with busy high
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic test_directed();
    set_config(64'd2, 64'h0000_0000_0000_0203);
    send_item(data_item(CODE_HIT, 4'h0, 1'b0));
    send_item(data_item(CODE_HIT, 4'hf, 1'b0));
    send_item(data_item(CODE_HIT, 4'hf, 1'b0));
    send_item(data_item(CODE_HIT_ROW, 4'h3, 1'b0));
    send_item(data_item(CODE_ROW, 4'h9, 1'b0));
    send_item(data_item(CODE_HIT, 4'h7, 1'b0));
    send_item(data_item(CODE_ROW, 4'h0, 1'b0));
    // row past this column's row count
    send_item(data_item(CODE_HIT, 4'h1, 1'b0));
    send_item(data_item(CODE_COL, 4'h0, 1'b0));
    send_item(data_item(CODE_HIT, 4'h2, 1'b0));
    // column past the column count
    send_item(data_item(CODE_COL, 4'h5, 1'b0));
    send_item(data_item(CODE_HIT, 4'h2, 1'b0));
    // end marker without last flag
    send_item(data_item(CODE_END, 4'h0, 1'b0));
    // hit that also ends the event
    send_item(data_item(CODE_HIT_ROW, 4'h0, 1'b1));
    send_item(ctrl_item(REQ_READ, 10'd0));
    send_item(ctrl_item(REQ_READ, 10'd15));
    send_item(ctrl_item(REQ_READ, 10'd39));
    send_item(ctrl_item(REQ_READ, 10'd50));
    send_item(ctrl_item(REQ_READ, 10'd1023));
    send_item(ctrl_item(ReqUnused, 10'd3));
    send_item(ctrl_item(REQ_CLEAR, 10'd15));
    send_item(ctrl_item(REQ_READ, 10'd15));
    send_item(data_item(CODE_HIT, 4'hf, 1'b0));
    send_item(ctrl_item(REQ_READ, 10'd15));
    send_item(data_item(CODE_END, 4'h0, 1'b1));
  endtask

  task automatic test_all_codes();
    for (int k = 0; k < 16; k++) send_item(data_item(4'(k), rand_chan(), 1'b0));
    send_item(data_item(CODE_END, rand_chan(), 1'b1));
  endtask

  task automatic test_extreme_config();
    // no columns: every hit is dropped
    set_config(64'd0, 64'd0);
    send_item(data_item(CODE_HIT, 4'h4, 1'b0));
    send_item(data_item(CODE_HIT_ROW, 4'hb, 1'b1));
    // count above the maximum, full-size columns overflow the global rows
    set_config({{$urandom, $urandom} & ~64'hf} | 64'hf, '1);
    send_item(data_item(CODE_HIT, 4'h8, 1'b0));
    send_item(data_item(CODE_COL, 4'h0, 1'b0));
    send_item(data_item(CODE_HIT, 4'h8, 1'b0));
    send_item(data_item(CODE_END, 4'h0, 1'b1));
    send_item(ctrl_item(REQ_READ, 10'd8));
    // all columns in use, zero rows each
    set_config(64'd8, 64'd0);
    send_item(data_item(CODE_HIT, 4'h1, 1'b0));
    send_item(data_item(CODE_END, 4'h0, 1'b1));
  endtask

  task automatic test_position_limits();
    set_config(64'd8, 64'h0808_0808_0808_0808);
    // row saturates at its top value
    repeat (260) send_item(data_item(CODE_ROW, rand_chan(), 1'b0));
    send_item(data_item(CODE_HIT_ROW, 4'h2, 1'b0));
    send_item(data_item(CODE_HIT, 4'h2, 1'b0));
    // column saturates too
    repeat (17) send_item(data_item(CODE_COL, rand_chan(), 1'b0));
    send_item(data_item(CODE_HIT, 4'h6, 1'b0));
    send_item(data_item(CODE_END, 4'h0, 1'b1));
    send_item(data_item(CODE_HIT, 4'h6, 1'b0));
    send_item(ctrl_item(REQ_READ, 10'd6));
  endtask

  // occasionally slips a stray item in ahead of the event byte
  task automatic send_noisy(input item_t it);
    int pick;
    if ($urandom_range(0, 9) == 0) begin
      pick = $urandom_range(0, 14);
      if (pick == 0) send_item(ctrl_item(REQ_CLEAR, 10'($urandom_range(0, 1023))));
      else if (pick < 5) send_item(ctrl_item(REQ_READ, 10'($urandom_range(0, 1023))));
      else if (pick < 9) send_item(ctrl_item(REQ_READ, 10'($urandom_range(0, 127))));
      else if (pick < 10) send_item(ctrl_item(ReqUnused, 10'($urandom_range(0, 1023))));
      else send_item(data_item(4'($urandom_range(0, 15)), rand_chan(),
                               1'($urandom_range(0, 3) == 0)));
    end
    send_item(it);
  endtask

  task automatic send_event();
    int ncol;
    int nrow;
    int nhit;
    int rc;
    ncol = $urandom_range(1, MaxCols);
    for (int c = 0; c < ncol; c++) begin
      rc = rows_of(c);
      nrow = $urandom_range(1, ((rc > 5) ? 5 : rc) + 1);
      for (int r = 0; r < nrow; r++) begin
        nhit = $urandom_range(0, 2);
        repeat (nhit) send_noisy(data_item(CODE_HIT, rand_chan(), 1'b0));
        if ($urandom_range(0, 1)) send_noisy(data_item(CODE_HIT_ROW, rand_chan(), 1'b0));
        else send_noisy(data_item(CODE_ROW, rand_chan(), 1'b0));
      end
      if (c < ncol - 1) send_noisy(data_item(CODE_COL, rand_chan(), 1'b0));
    end
    if ($urandom_range(0, 9) == 0) send_noisy(data_item(CODE_HIT, rand_chan(), 1'b1));
    else send_noisy(data_item(CODE_END, rand_chan(), 1'b1));
    // read back a counter near the rows just filled
    send_item(ctrl_item(REQ_READ, 10'($urandom_range(0, 16 * 24 - 1))));
  endtask

  task automatic test_random_events();
    int target;
    logic [63:0] cols_word;
    logic [63:0] rows_pk;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin cols_word = 64'd8; rows_pk = rows_word(1, 4); end
        1: begin cols_word = 64'($urandom_range(1, 7)); rows_pk = rows_word(0, 5); end
        2: begin cols_word = 64'($urandom_range(9, 15)); rows_pk = rows_word(1, 8); end
        3: begin cols_word = 64'($urandom_range(0, 15)); rows_pk = {$urandom, $urandom}; end
        default: begin cols_word = 64'd8; rows_pk = rows_word(1, 3); end
      endcase
      set_config(cols_word, rows_pk);
      target = n_items + 10;
      while (n_items < target) send_event();
    end
  endtask

  initial begin
    do_reset();
    test_directed();
    test_all_codes();
    test_extreme_config();
    test_position_limits();
    test_random_events();
    drain();
    $display("Ran %0d items over %0d register settings: %0d hits counted, %0d reads, %0d clears",
             n_items, n_settings, n_hits, n_reads, n_clears);
    $display("%0d mismatches, %0d results outstanding", mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
